@@ hdl/assert_macros.svh @@
// Assertion macros shared by the key search RTL.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a property in the same cycle
`define ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Check that a condition implies a property in the next cycle
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ hdl/bks_pkg.sv @@
// Shared types and constants for the tree node key search block.
// Used by bks_ctrl, bks_datapath and the top level; depends on nothing.
package bks_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 256;
  localparam int KEY_BITS    = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int BOUND_W     = CNT_W + 1;

  // Field widths on the ports
  localparam int KIND_W      = 3;
  localparam int KEY_W       = 64;
  localparam int ADDR_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int INDEX_W     = 9;
  localparam int IN_DATA_W   = KEY_W + ADDR_W;
  localparam int OUT_FIELD_W = INDEX_W + ADDR_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_EXACT  = 3'd2,
    KIND_INSERT = 3'd3,
    KIND_FLOOR  = 3'd4,
    KIND_ADDR   = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Table read address source
  typedef enum logic [2:0] {
    RD_MID_NEW,
    RD_MID_M1,
    RD_MID_P1,
    RD_LAST,
    RD_FIRST,
    RD_SCAN
  } rd_sel_t;

  // Result index source
  typedef enum logic [1:0] {
    IDX_ZERO,
    IDX_MID,
    IDX_COUNT,
    IDX_SCAN
  } idx_sel_t;

  typedef struct packed {
    logic     capture;
    logic     clear_count;
    logic     append;
    logic     init_bounds;
    logic     mid_up;
    logic     mid_load;
    logic     lo_step;
    logic     hi_step;
    logic     scan_clear;
    logic     scan_step;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     res_load;
    status_t  res_status;
    idx_sel_t res_idx_sel;
    logic     res_addr_rd;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic stored_lt;
    logic stored_gt;
    logic mid_zero;
    logic mid_last;
    logic count_zero;
    logic count_full;
    logic scan_end;
    logic addr_hit;
  } dp_stat_t;

endpackage

@@ hdl/bks_datapath.sv @@
// Datapath of the key search block: entry table, search bounds, scan counter,
// key comparator and result registers. Depends on bks_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bks_datapath import bks_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [KEY_W-1:0]     key_in,
  input  logic [ADDR_W-1:0]    addr_in,
  output status_t              status,
  output logic [INDEX_W-1:0]   entry_index,
  output logic [ADDR_W-1:0]    found_addr
);

  // Entry table
  logic [KEY_BITS-1:0] key_mem  [MAX_ENTRIES];
  logic [ADDR_W-1:0]   addr_mem [MAX_ENTRIES];

  logic [KEY_BITS-1:0]       key_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [CNT_W-1:0]          count;
  logic signed [BOUND_W-1:0] lo;
  logic signed [BOUND_W-1:0] hi;
  logic [IDX_W-1:0]          mid;
  logic [CNT_W-1:0]          scan;
  logic [IDX_W-1:0]          rd_addr;
  logic [KEY_BITS-1:0]       rd_key;
  logic [ADDR_W-1:0]         rd_child;
  status_t                   res_status;
  logic [CNT_W-1:0]          res_idx;
  logic [ADDR_W-1:0]         res_addr;

  logic [BOUND_W:0]  mid_sum;
  logic [IDX_W-1:0]  mid_new;
  logic [CNT_W-1:0]  res_idx_next;

  // Midpoint of the live bounds, rounded down or up; only used while lo <= hi
  assign mid_sum = {lo[BOUND_W-1], lo} + {hi[BOUND_W-1], hi}
                 + (BOUND_W + 1)'(cmd.mid_up);
  assign mid_new = mid_sum[IDX_W:1];

  // Select table read address
  always_comb begin
    unique case (cmd.rd_sel)
      RD_MID_NEW: rd_addr = mid_new;
      RD_MID_M1:  rd_addr = mid - IDX_W'(1);
      RD_MID_P1:  rd_addr = mid + IDX_W'(1);
      RD_LAST:    rd_addr = IDX_W'(count - CNT_W'(1));
      RD_FIRST:   rd_addr = '0;
      RD_SCAN:    rd_addr = scan[IDX_W-1:0];
      default:    rd_addr = '0;
    endcase
  end

  // Write on append, registered read on probe
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      key_mem[count[IDX_W-1:0]]  <= key_q;
      addr_mem[count[IDX_W-1:0]] <= addr_q;
    end
    if (cmd.rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_child <= addr_mem[rd_addr];
    end
  end

  // Capture the item payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_q  <= key_in[KEY_BITS-1:0];
      addr_q <= addr_in;
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_count) begin
      count <= '0;
    end else if (cmd.append) begin
      count <= count + CNT_W'(1);
    end
  end

  // Search bounds, midpoint and scan counter
  always_ff @(posedge clk) begin
    if (cmd.init_bounds) begin
      lo <= '0;
      hi <= $signed({1'b0, count}) - BOUND_W'(1);
    end else begin
      if (cmd.lo_step) lo <= $signed(BOUND_W'(mid)) + BOUND_W'(1);
      if (cmd.hi_step) hi <= $signed(BOUND_W'(mid)) - BOUND_W'(1);
    end
    if (cmd.mid_load) mid <= mid_new;
    if (cmd.scan_clear) begin
      scan <= '0;
    end else if (cmd.scan_step) begin
      scan <= scan + CNT_W'(1);
    end
  end

  // Pick the result index
  always_comb begin
    unique case (cmd.res_idx_sel)
      IDX_ZERO:  res_idx_next = '0;
      IDX_MID:   res_idx_next = CNT_W'(mid);
      IDX_COUNT: res_idx_next = count;
      IDX_SCAN:  res_idx_next = scan;
      default:   res_idx_next = '0;
    endcase
  end

  // Stage the result, then move it to the output register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_idx    <= res_idx_next;
      res_addr   <= cmd.res_addr_rd ? rd_child : '0;
    end
    if (cmd.out_load) begin
      status      <= res_status;
      entry_index <= INDEX_W'(res_idx);
      found_addr  <= res_addr;
    end
  end

  // Status toward the controller
  assign stat.in_range   = (lo <= hi);
  assign stat.stored_lt  = (rd_key < key_q);
  assign stat.stored_gt  = (rd_key > key_q);
  assign stat.mid_zero   = (mid == '0);
  assign stat.mid_last   = ((CNT_W'(mid) + CNT_W'(1)) == count);
  assign stat.count_zero = (count == '0);
  assign stat.count_full = (count == CNT_W'(MAX_ENTRIES));
  assign stat.scan_end   = (scan == count);
  assign stat.addr_hit   = (rd_child == addr_q);

  `ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(MAX_ENTRIES), "entry count above table size")
  `ASSERT_SAME(a_read_written, cmd.rd_en, CNT_W'(rd_addr) < count, "probe beyond filled entries")
  `ASSERT_SAME(a_append_room, cmd.append, !stat.count_full, "append into full table")

endmodule

@@ hdl/bks_ctrl.sv @@
// Controller of the key search block: sequences each query's probes and the
// output handshake. Depends on bks_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bks_ctrl import bks_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  kind_t    kind,
  output logic     m_tvalid,
  input  logic     m_tready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [3:0] {
    IDLE, EXEC,
    E_MID, E_CHK,
    I_LAST, I_MID, I_CHK, I_PREV,
    F_FIRST, F_MID, F_CHK, F_NEXT,
    S_ISSUE, S_CHK,
    DONE
  } state_t;

  state_t state, state_next;
  kind_t  kind_q;

  // Add a result load to a command
  function automatic dp_cmd_t with_result(dp_cmd_t c, status_t s, idx_sel_t i,
                                          logic a);
    dp_cmd_t r;
    r = c;
    r.res_load    = 1'b1;
    r.res_status  = s;
    r.res_idx_sel = i;
    r.res_addr_rd = a;
    return r;
  endfunction

  // Decode state and datapath status into commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = (state == IDLE) && !rst;
    unique case (state)
      IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.capture = 1'b1;
          state_next  = EXEC;
        end
      end
      EXEC: begin
        unique case (kind_q)
          KIND_CLEAR: begin
            cmd.clear_count = 1'b1;
            cmd = with_result(cmd, ST_OK, IDX_ZERO, 1'b0);
            state_next = DONE;
          end
          KIND_APPEND: begin
            if (stat.count_full) begin
              cmd = with_result(cmd, ST_FULL, IDX_ZERO, 1'b0);
            end else begin
              cmd.append = 1'b1;
              cmd = with_result(cmd, ST_OK, IDX_COUNT, 1'b0);
            end
            state_next = DONE;
          end
          KIND_EXACT: begin
            cmd.init_bounds = 1'b1;
            state_next = E_MID;
          end
          KIND_INSERT: begin
            if (stat.count_zero) begin
              cmd = with_result(cmd, ST_OK, IDX_ZERO, 1'b0);
              state_next = DONE;
            end else begin
              cmd.init_bounds = 1'b1;
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_LAST;
              state_next = I_LAST;
            end
          end
          KIND_FLOOR: begin
            if (stat.count_zero) begin
              cmd = with_result(cmd, ST_EMPTY, IDX_ZERO, 1'b0);
              state_next = DONE;
            end else begin
              cmd.init_bounds = 1'b1;
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_FIRST;
              state_next = F_FIRST;
            end
          end
          KIND_ADDR: begin
            cmd.scan_clear = 1'b1;
            state_next = S_ISSUE;
          end
          default: begin
            cmd = with_result(cmd, ST_NOT_FOUND, IDX_ZERO, 1'b0);
            state_next = DONE;
          end
        endcase
      end
      // Exact find: midpoint rounded down
      E_MID: begin
        if (stat.in_range) begin
          cmd.mid_load = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_MID_NEW;
          state_next   = E_CHK;
        end else begin
          cmd = with_result(cmd, ST_NOT_FOUND, IDX_ZERO, 1'b0);
          state_next = DONE;
        end
      end
      E_CHK: begin
        priority if (stat.stored_lt) begin
          cmd.lo_step = 1'b1;
          state_next  = E_MID;
        end else if (stat.stored_gt) begin
          cmd.hi_step = 1'b1;
          state_next  = E_MID;
        end else begin
          cmd = with_result(cmd, ST_OK, IDX_MID, 1'b0);
          state_next = DONE;
        end
      end
      // Insert position: last entry first, then midpoint rounded up
      I_LAST: begin
        if (stat.stored_lt) begin
          cmd = with_result(cmd, ST_OK, IDX_COUNT, 1'b0);
          state_next = DONE;
        end else begin
          state_next = I_MID;
        end
      end
      I_MID: begin
        if (stat.in_range) begin
          cmd.mid_up   = 1'b1;
          cmd.mid_load = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_MID_NEW;
          state_next   = I_CHK;
        end else begin
          cmd = with_result(cmd, ST_NOT_FOUND, IDX_ZERO, 1'b0);
          state_next = DONE;
        end
      end
      I_CHK: begin
        priority if (stat.stored_lt) begin
          cmd.lo_step = 1'b1;
          state_next  = I_MID;
        end else if (stat.stored_gt) begin
          // Stage the midpoint as answer; the previous entry decides
          cmd = with_result(cmd, ST_OK, IDX_MID, 1'b0);
          if (stat.mid_zero) begin
            state_next = DONE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_MID_M1;
            state_next = I_PREV;
          end
        end else begin
          cmd = with_result(cmd, ST_DUPLICATE, IDX_MID, 1'b0);
          state_next = DONE;
        end
      end
      I_PREV: begin
        if (stat.stored_lt) begin
          state_next = DONE;
        end else begin
          cmd.hi_step = 1'b1;
          state_next  = I_MID;
        end
      end
      // Floor child: first entry first, then midpoint rounded up
      F_FIRST: begin
        if (stat.stored_gt) begin
          cmd = with_result(cmd, ST_OK, IDX_ZERO, 1'b1);
          state_next = DONE;
        end else begin
          state_next = F_MID;
        end
      end
      F_MID: begin
        if (stat.in_range) begin
          cmd.mid_up   = 1'b1;
          cmd.mid_load = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_MID_NEW;
          state_next   = F_CHK;
        end else begin
          cmd = with_result(cmd, ST_NOT_FOUND, IDX_ZERO, 1'b0);
          state_next = DONE;
        end
      end
      F_CHK: begin
        priority if (stat.stored_lt) begin
          // Stage the midpoint and its address; the next entry decides
          cmd = with_result(cmd, ST_OK, IDX_MID, 1'b1);
          if (stat.mid_last) begin
            state_next = DONE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_MID_P1;
            state_next = F_NEXT;
          end
        end else if (stat.stored_gt) begin
          cmd.hi_step = 1'b1;
          state_next  = F_MID;
        end else begin
          cmd = with_result(cmd, ST_OK, IDX_MID, 1'b1);
          state_next = DONE;
        end
      end
      F_NEXT: begin
        if (stat.stored_gt) begin
          state_next = DONE;
        end else begin
          cmd.lo_step = 1'b1;
          state_next  = F_MID;
        end
      end
      // Address scan: read one entry, then compare its address, until a hit or the end
      S_ISSUE: begin
        if (stat.scan_end) begin
          cmd = with_result(cmd, ST_NOT_FOUND, IDX_ZERO, 1'b0);
          state_next = DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_SCAN;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.addr_hit) begin
          cmd = with_result(cmd, ST_OK, IDX_SCAN, 1'b0);
          state_next = DONE;
        end else begin
          cmd.scan_step = 1'b1;
          state_next    = S_ISSUE;
        end
      end
      // Hand the result to the output register once it is free
      DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State, captured kind and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      kind_q   <= KIND_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) kind_q <= kind;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `ASSERT_SAME(a_out_free, cmd.out_load, !m_tvalid || m_tready, "result overwrites pending beat")
  `ASSERT_NEXT(a_out_valid, cmd.out_load, m_tvalid, "loaded result not presented")
  `ASSERT_NEXT(a_capture_exec, cmd.capture, state == EXEC, "accepted beat not executed")

endmodule

@@ hdl/btree_node_key_search_unit.sv @@
// Top level of the tree node key search block: sorted key table with binary
// and linear search. Instantiates bks_ctrl and bks_datapath; uses bks_pkg.
//
// Usage: one request beat on the s_ channel gives one result beat on the m_
// channel, in order. s_tuser carries the request kind (clear, append, exact
// find, insert position, floor child, find by address); s_tdata carries the
// key and child address. m_tuser carries the status, m_tdata the entry index
// and the floor child address.
// Each request runs its own steps: clear and append go from the accept straight
// to the result stage. Exact find probes the midpoint of the bounds, reading the
// entry and then comparing it, and stops on a hit or when the bounds cross.
// Insert and floor first read the last or first entry, then probe the same way
// and may read the neighbor of a probe to decide; a full 256-entry table needs
// at most 9 probes. Find by address reads and compares one entry after another
// until a hit or the end of the filled entries.
// One request is worked at a time; the next is taken once the previous
// result sits in the output register, so a stalled receiver only blocks the
// block when a second result is ready. Reset empties the table (the count
// goes to zero) and drops any pending result; no beat is taken during reset.

module btree_node_key_search_unit import bks_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // search_key[63:0], child_addr[95:64]
  input  logic [KIND_W-1:0]     s_tuser,   // kind[2:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // entry_index[8:0], found_addr[40:9], zero pad
  output logic [STATUS_W-1:0]   m_tuser    // status[2:0]
);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  status_t            status;
  logic [INDEX_W-1:0] entry_index;
  logic [ADDR_W-1:0]  found_addr;

  bks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .kind     (kind_t'(s_tuser)),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  bks_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .key_in      (s_tdata[KEY_W-1:0]),
    .addr_in     (s_tdata[IN_DATA_W-1:KEY_W]),
    .status      (status),
    .entry_index (entry_index),
    .found_addr  (found_addr)
  );

  // Pack the result beat
  assign m_tdata = OUT_DATA_W'({found_addr, entry_index});
  assign m_tuser = status;

endmodule

@@ verif/tb_btree_node_key_search_unit.sv @@
// Self-checking testbench for btree_node_key_search_unit: fills the key table,
// runs exact, insert, floor and address searches with random stalls on both
// sides, and checks each result beat. Depends on bks_pkg and the RTL top level.

import bks_pkg::*;

typedef struct packed {
  status_t     status;
  logic [8:0]  index;
  logic [31:0] addr;
} search_outcome_t;

// Mirror of the node table; predicts the outcome of each accepted request
class node_table_tracker;
  logic [63:0]     keys [MAX_ENTRIES];
  logic [31:0]     addrs [MAX_ENTRIES];
  int              count;
  search_outcome_t awaited [$];
  int              fail_count;
  int              results_seen;

  function new();
    count = 0;
    fail_count = 0;
    results_seen = 0;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  // Apply one request to the mirror and return the result it must produce
  function search_outcome_t resolve(logic [2:0] kind, logic [63:0] key, logic [31:0] addr);
    search_outcome_t r;
    int lo;
    int hi;
    int mid;
    bit done;
    r.status = ST_OK;
    r.index = '0;
    r.addr = '0;
    done = 0;
    lo = 0;
    hi = count - 1;
    case (kind)
      KIND_CLEAR: count = 0;
      KIND_APPEND: begin
        if (count >= MAX_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          keys[count] = key;
          addrs[count] = addr;
          r.index = INDEX_W'(count);
          count++;
        end
      end
      // Midpoint rounds down; stop on the first equal probe
      KIND_EXACT: begin
        r.status = ST_NOT_FOUND;
        while (!done && lo <= hi) begin
          mid = (lo + hi) / 2;
          if (keys[mid] < key) lo = mid + 1;
          else if (keys[mid] > key) hi = mid - 1;
          else begin
            r.status = ST_OK;
            r.index = INDEX_W'(mid);
            done = 1;
          end
        end
      end
      // Lowest index whose key is greater; equal probe is a duplicate
      KIND_INSERT: begin
        if (count == 0) begin
          r.index = '0;
        end else if (keys[count-1] < key) begin
          r.index = INDEX_W'(count);
        end else begin
          r.status = ST_NOT_FOUND;
          while (!done && lo <= hi) begin
            mid = (lo + hi + 1) / 2;
            if (keys[mid] < key) begin
              lo = mid + 1;
            end else if (keys[mid] > key) begin
              if (mid == 0 || keys[mid-1] < key) begin
                r.status = ST_OK;
                r.index = INDEX_W'(mid);
                done = 1;
              end else begin
                hi = mid - 1;
              end
            end else begin
              r.status = ST_DUPLICATE;
              r.index = INDEX_W'(mid);
              done = 1;
            end
          end
        end
      end
      // Highest key at or below the wanted key, else the first entry
      KIND_FLOOR: begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else if (keys[0] > key) begin
          r.addr = addrs[0];
        end else begin
          r.status = ST_NOT_FOUND;
          while (!done && lo <= hi) begin
            mid = (lo + hi + 1) / 2;
            if (keys[mid] < key) begin
              if (mid == count - 1 || keys[mid+1] > key) done = 1;
              else lo = mid + 1;
            end else if (keys[mid] > key) begin
              hi = mid - 1;
            end else begin
              done = 1;
            end
            if (done) begin
              r.status = ST_OK;
              r.index = INDEX_W'(mid);
              r.addr = addrs[mid];
            end
          end
        end
      end
      // Linear walk for the first entry with this address
      KIND_ADDR: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < count && !done; i++) begin
          if (addrs[i] == addr) begin
            r.status = ST_OK;
            r.index = INDEX_W'(i);
            done = 1;
          end
        end
      end
      default: r.status = ST_NOT_FOUND;
    endcase
    if (r.status != ST_OK && r.status != ST_DUPLICATE) begin
      r.index = '0;
      r.addr = '0;
    end
    return r;
  endfunction

  function void note_request(logic [2:0] kind, logic [63:0] key, logic [31:0] addr);
    awaited.push_back(resolve(kind, key, addr));
  endfunction

  function void check_result(logic [2:0] status, logic [8:0] index, logic [31:0] addr);
    search_outcome_t e;
    results_seen++;
    if (awaited.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result beat %0d unexpected: status %0d index %0d addr %h",
                 results_seen, status, index, addr);
      return;
    end
    e = awaited.pop_front();
    if (status !== e.status || index !== e.index || addr !== e.addr) begin
      fail_count++;
      if (fail_count <= 10)
        $display("beat %0d: expected st %0d ix %0d ad %h, got st %0d ix %0d ad %h",
                 results_seen, e.status, e.index, e.addr, status, index, addr);
    end
  endfunction
endclass

module tb_btree_node_key_search_unit;

  localparam logic [KIND_W-1:0] KIND_UNUSED6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED7 = 3'd7;
  localparam int TOTAL_ITEMS = 1250;
  localparam int CALM_AFTER  = 1100;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 600;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // search_key[63:0], child_addr[95:64]
  logic [KIND_W-1:0]     s_tuser;   // kind[2:0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // entry_index[8:0], found_addr[40:9], zero pad
  logic [STATUS_W-1:0]   m_tuser;   // status[2:0]

  node_table_tracker tracker = new();

  bit          idle_on;
  bit          long_hold_req;
  int          items_sent;
  logic [63:0] table_keys [$];
  logic [31:0] table_addrs [$];
  logic [63:0] build [MAX_ENTRIES];

  btree_node_key_search_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #30000000;
    $display("btree_node_key_search_unit: mismatch");
    $finish;
  end

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Offer one request beat, with an optional idle burst first; returns at the accept edge
  task automatic push_request(logic [2:0] kind, logic [63:0] key, logic [31:0] addr);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {addr, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_request(kind, key, addr);
    items_sent++;
  endtask

  // Stop offering until every expected result beat has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() > 0) @(posedge clk);
  endtask

  // Result side: random stall bursts plus one long hold-off on request
  initial begin : result_sink
    int stall;
    int hold;
    stall = 0;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 0;
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 15) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      tracker.check_result(m_tuser, m_tdata[8:0], m_tdata[40:9]);
  end

  initial begin : stimulus
    int          seq_no;
    int          n;
    int          queries;
    int          mode;
    int          pick;
    logic [63:0] key;
    logic [63:0] span;
    logic [31:0] addr;
    logic [2:0]  kind;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    rst = 1'b1;
    idle_on = 1;
    long_hold_req = 0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table: every search kind, then the unused kinds
    push_request(KIND_FLOOR, 64'd7, 32'd0);
    push_request(KIND_EXACT, 64'd7, 32'd0);
    push_request(KIND_INSERT, 64'd7, 32'd0);
    push_request(KIND_ADDR, 64'd0, 32'd0);
    push_request(KIND_UNUSED6, '1, '1);
    push_request(KIND_UNUSED7, 64'd0, 32'd0);
    // Four entries spanning the key range
    push_request(KIND_APPEND, 64'd0, 32'h0000_0000);
    push_request(KIND_APPEND, 64'd5, 32'hA5A5_A5A5);
    push_request(KIND_APPEND, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
    push_request(KIND_APPEND, '1, 32'h5A5A_5A5A);
    push_request(KIND_EXACT, '1, 32'd0);
    push_request(KIND_EXACT, 64'd3, 32'd0);
    push_request(KIND_INSERT, 64'd5, 32'd0);
    push_request(KIND_INSERT, 64'd6, 32'd0);
    push_request(KIND_INSERT, '1, 32'd0);
    push_request(KIND_FLOOR, 64'd4, 32'd0);
    push_request(KIND_FLOOR, '1, 32'd0);
    push_request(KIND_ADDR, 64'd0, 32'hFFFF_FFFF);
    push_request(KIND_ADDR, 64'd0, 32'h1234_5678);
    // Single entry: key below all, key above all, then an out-of-order append
    push_request(KIND_CLEAR, 64'd0, 32'd0);
    push_request(KIND_APPEND, 64'd10, 32'hC0DE_0001);
    push_request(KIND_EXACT, 64'd3, 32'd0);
    push_request(KIND_FLOOR, 64'd3, 32'd0);
    push_request(KIND_INSERT, 64'd11, 32'd0);
    push_request(KIND_APPEND, 64'd2, 32'hC0DE_0002);

    // Random runs: clear, fill, then a burst of queries against the fill
    seq_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      idle_on = (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      if (seq_no == 5 || $urandom_range(0, 7) == 0) wait_drained();
      if (seq_no == 1 || $urandom_range(0, 7) != 0)
        push_request(KIND_CLEAR, rand_key(), $urandom);

      if (seq_no == 1) begin
        n = MAX_ENTRIES;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) n = 0;
        else if (pick < 4) n = $urandom_range(13, 64);
        else n = $urandom_range(1, 12);
      end

      // Key layout: dense run, dense run ending at all ones, spread out, or unsorted
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        key = rand_key();
        for (int i = 0; i < n; i++) begin
          build[i] = key;
          key = key + $urandom_range(0, 2);
        end
      end else if (mode < 6) begin
        key = '1;
        for (int i = n - 1; i >= 0; i--) begin
          build[i] = key;
          key = key - $urandom_range(0, 3);
        end
      end else if (mode < 9) begin
        span = 64'hFFFF_FFFF_FFFF_FFFF / (n + 1);
        key = '0;
        for (int i = 0; i < n; i++) begin
          key = key + (rand_key() % span);
          build[i] = key;
          key = key + 1;
        end
      end else begin
        for (int i = 0; i < n; i++)
          build[i] = $urandom_range(0, 1) ? rand_key() : 64'($urandom_range(0, 20));
      end

      table_keys.delete();
      table_addrs.delete();
      for (int i = 0; i < n; i++) begin
        addr = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
        push_request(KIND_APPEND, build[i], addr);
        table_keys.push_back(build[i]);
        table_addrs.push_back(addr);
      end
      // Overflow a full table
      if (n == MAX_ENTRIES) begin
        repeat (2) push_request(KIND_APPEND, rand_key(), $urandom);
      end

      if (seq_no == 3) long_hold_req = 1;

      queries = $urandom_range(4, 20);
      repeat (queries) begin
        pick = $urandom_range(0, 59);
        if (pick == 0) kind = $urandom_range(0, 1) ? KIND_UNUSED6 : KIND_UNUSED7;
        else if (pick < 4) kind = KIND_APPEND;
        else if (pick == 4) kind = KIND_CLEAR;
        else begin
          case (pick % 4)
            0: kind = KIND_EXACT;
            1: kind = KIND_INSERT;
            2: kind = KIND_FLOOR;
            default: kind = KIND_ADDR;
          endcase
        end
        // Aim mostly at stored keys and their neighbors
        addr = $urandom;
        if (table_keys.size() == 0) begin
          key = rand_key();
        end else begin
          pick = $urandom_range(0, table_keys.size() - 1);
          if ($urandom_range(0, 1) == 0) addr = table_addrs[pick];
          case ($urandom_range(0, 7))
            0, 1, 2: key = table_keys[pick];
            3: key = table_keys[pick] + 1;
            4: key = table_keys[pick] - 1;
            5: key = rand_key();
            6: key = '0;
            default: key = '1;
          endcase
        end
        push_request(kind, key, addr);
      end
      seq_no++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.pending() == 0) begin
      $display("btree_node_key_search_unit: match");
    end else begin
      $display("btree_node_key_search_unit: mismatch");
    end
    $finish;
  end

endmodule
